// File: design/vpi_pkg.sv
package vpi_pkg;
    localparam int CW = 21;
    localparam int DW = 22;                 // center - pos
    localparam int SQW = 2 * DW + 2;        // sum of three squares
    localparam int RW = 20;
    localparam int QNW = 64;                // numerator width
    localparam int QDW = 41;                // radius * dist width
    localparam int KEEP_ONE = 65536;

    localparam logic [2:0] REG_ACC_X = 3'd0;
    localparam logic [2:0] REG_ACC_Y = 3'd1;
    localparam logic [2:0] REG_ACC_Z = 3'd2;
    localparam logic [2:0] REG_KEEP  = 3'd3;
    localparam logic [2:0] REG_RAD   = 3'd4;
    localparam logic [2:0] REG_STR   = 3'd5;
    localparam logic [2:0] REG_CTR   = 3'd6;

    typedef struct packed {
        logic signed [CW-1:0] pos_x, pos_y, pos_z, old_x, old_y, old_z;
        logic                 hold;
    } t_item;

    typedef struct packed {
        logic signed [CW-1:0] next_x, next_y, next_z, prior_x, prior_y, prior_z;
        logic                 clipped;
    } t_result;
endpackage

// File: design/vpi_sqrt_stage.sv
// one restoring square root step, registered, with a stall enable
module vpi_sqrt_stage import vpi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [4:0]           i_bit_idx,
    input  logic [SQW-1:0]       i_rem,
    input  logic [SQW-1:0]       i_root,
    output logic [SQW-1:0]       o_rem,
    output logic [SQW-1:0]       o_root
);
    logic [SQW-1:0] w_bit, w_trial, n_rem, n_root;
    logic [SQW-1:0] r_rem, r_root;

    always_comb begin
        w_bit = '0;
        w_bit[{i_bit_idx, 1'b0}] = 1'b1;
        w_trial = i_root + w_bit;
        if (i_rem >= w_trial) begin
            n_rem  = i_rem - w_trial;
            n_root = (i_root >> 1) + w_bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

// File: design/vpi_div_stage.sv
// one radix-2 restoring division step on a quotient bit
module vpi_div_stage import vpi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [QDW:0]         i_den,
    input  logic [QDW+1:0]       i_rem,
    input  logic [QNW:0]         i_num,
    output logic [QDW+1:0]       o_rem,
    output logic [QNW:0]         o_num
);
    logic [QDW+1:0] w_sh, n_rem;
    logic [QNW:0]   n_num;
    logic [QDW+1:0] r_rem;
    logic [QNW:0]   r_num;

    always_comb begin
        w_sh  = {i_rem[QDW:0], i_num[QNW]};
        n_num = {i_num[QNW-1:0], 1'b0};
        if (w_sh >= {1'b0, i_den}) begin
            n_rem    = w_sh - {1'b0, i_den};
            n_num[0] = 1'b1;
        end else begin
            n_rem = w_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
endmodule

// File: design/verlet_particle_integrator_core.sv
// channel | dir | tdata fields (low bit up)                                        | tuser
// s_axis  | in  | pos_x, pos_y, pos_z, old_x, old_y, old_z (21 b each), pad to 128  | hold
// m_axis  | out | next_x..z, prior_x..z (21 b each), pad to 128                     | clipped
// cfg     | in  | i_cfg_we, i_cfg_idx (3 b), i_cfg_data (63 b)                      | -
// one item per cycle while the output is not stalled; from accept to result: 3 front stages, 23 square root
// steps, 2 product stages, 65 divide steps and a final sum and saturate stage
// i_rst_n is synchronous active low; it clears the valid bits and loads the registers
// a stall at the output freezes the whole pipe; ready returns when the last stage drains
module verlet_particle_integrator_core import vpi_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,  // pos_x, pos_y, pos_z, old_x, old_y, old_z
    input  logic           s_axis_tuser,  // hold
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [127:0]   m_axis_tdata,  // next_x, next_y, next_z, prior_x, prior_y, prior_z
    output logic           m_axis_tuser,  // clipped
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [62:0]    i_cfg_data
);
    localparam int NSQ = SQW / 2;
    localparam int NDV = QNW + 1;
    localparam int NST = 3 + NSQ + 2 + NDV + 1;

    logic signed [CW-1:0] r_acc [3];
    logic [16:0]          r_keep;
    logic [RW-1:0]        r_rad;
    logic signed [CW-1:0] r_str;
    logic [62:0]          r_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc[0] <= '0; r_acc[1] <= '0; r_acc[2] <= '0;
            r_keep <= 17'(KEEP_ONE);
            r_rad <= '0; r_str <= '0; r_ctr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACC_X: r_acc[0] <= i_cfg_data[CW-1:0];
                REG_ACC_Y: r_acc[1] <= i_cfg_data[CW-1:0];
                REG_ACC_Z: r_acc[2] <= i_cfg_data[CW-1:0];
                REG_KEEP:  r_keep <= i_cfg_data[16:0];
                REG_RAD:   r_rad <= i_cfg_data[RW-1:0];
                REG_STR:   r_str <= i_cfg_data[CW-1:0];
                REG_CTR:   r_ctr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe control: whole pipe advances when the output is free
    logic r_vld [NST];
    logic w_en;
    assign w_en = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NST; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // item side data carried down the pipe
    typedef struct packed {
        t_item                item;
        logic signed [CW+1:0] base_x, base_y, base_z;  // pos + v + acc
        logic                 fld;                     // field applies
        logic [2:0]           neg;
    } t_side;

    t_side r_side [NST-1];
    t_item w_in;
    assign w_in.pos_x = s_axis_tdata[20:0];
    assign w_in.pos_y = s_axis_tdata[41:21];
    assign w_in.pos_z = s_axis_tdata[62:42];
    assign w_in.old_x = s_axis_tdata[83:63];
    assign w_in.old_y = s_axis_tdata[104:84];
    assign w_in.old_z = s_axis_tdata[125:105];
    assign w_in.hold  = s_axis_tuser;

    // stage 0: deltas, velocity products
    logic signed [DW-1:0] r_dl [3];
    logic signed [DW+17:0] r_vp [3];
    logic signed [CW-1:0] w_p [3], w_o [3], w_c [3];
    logic [16:0] w_keep;
    t_side w_s0;
    always_comb begin
        w_p[0] = w_in.pos_x; w_p[1] = w_in.pos_y; w_p[2] = w_in.pos_z;
        w_o[0] = w_in.old_x; w_o[1] = w_in.old_y; w_o[2] = w_in.old_z;
        for (int k = 0; k < 3; k++) w_c[k] = r_ctr[k*CW +: CW];
        w_keep = (r_keep > 17'(KEEP_ONE)) ? 17'(KEEP_ONE) : r_keep;
        w_s0 = '0;
        w_s0.item = w_in;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_s0;
            for (int k = 0; k < 3; k++) begin
                r_dl[k] <= DW'(w_c[k]) - DW'(w_p[k]);
                r_vp[k] <= (DW+18)'(DW'(w_p[k]) - DW'(w_o[k])) *
                           $signed({1'b0, w_keep});
            end
        end
    end

    // stage 1: abs, squares, base sum, near test
    logic [DW-1:0]  w_ab [3];
    logic [DW-1:0]  r_ab [3];
    logic [2*DW-1:0] r_sq [3];
    logic signed [CW+1:0] w_v [3], w_base [3];
    logic w_near;
    t_side w_s1;
    always_comb begin
        w_near = (r_rad != '0);
        for (int k = 0; k < 3; k++) begin
            w_ab[k] = r_dl[k][DW-1] ? DW'(-r_dl[k]) : r_dl[k];
            if (w_ab[k] >= DW'(r_rad)) w_near = 1'b0;
            w_v[k] = (CW+2)'((r_vp[k] + (DW+18)'(32768)) >>> 16);
        end
        w_base[0] = w_v[0] + (CW+2)'(r_side[0].item.pos_x) + (CW+2)'(r_acc[0]);
        w_base[1] = w_v[1] + (CW+2)'(r_side[0].item.pos_y) + (CW+2)'(r_acc[1]);
        w_base[2] = w_v[2] + (CW+2)'(r_side[0].item.pos_z) + (CW+2)'(r_acc[2]);
        w_s1 = r_side[0];
        w_s1.base_x = w_base[0];
        w_s1.base_y = w_base[1];
        w_s1.base_z = w_base[2];
        w_s1.fld = w_near;
        for (int k = 0; k < 3; k++) w_s1.neg[k] = r_dl[k][DW-1] != r_str[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[1] <= w_s1;
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= w_ab[k];
                r_sq[k] <= w_ab[k] * w_ab[k];
            end
        end
    end

    // stage 2: sum of squares, inside radius check
    logic [SQW-1:0] r_ss;
    logic [SQW-1:0] w_ss;
    assign w_ss = SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
    logic [DW-1:0] r_ab2 [3];
    t_side w_s2;
    always_comb begin
        w_s2 = r_side[1];
        w_s2.fld = r_side[1].fld && (w_ss != '0) &&
                   (w_ss < SQW'(r_rad) * SQW'(r_rad));
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[2] <= w_s2;
            r_ss <= w_ss;
            r_ab2 <= r_ab;
        end
    end

    // square root chain; abs deltas ride alongside
    logic [SQW-1:0] w_srem [NSQ+1], w_sroot [NSQ+1];
    logic [DW-1:0]  r_abq [NSQ][3];
    assign w_srem[0] = r_ss;
    assign w_sroot[0] = '0;
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        vpi_sqrt_stage u_st (
            .i_clk(i_clk), .i_en(w_en), .i_bit_idx(5'(NSQ - 1 - g)),
            .i_rem(w_srem[g]), .i_root(w_sroot[g]),
            .o_rem(w_srem[g+1]), .o_root(w_sroot[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[3+g] <= r_side[2+g];
                r_abq[g] <= (g == 0) ? r_ab2 : r_abq[g == 0 ? 0 : g-1];
            end
        end
    end

    // two stages: products a*|s| and r*d, r-d; then numerators
    localparam int SA = 3 + NSQ - 1;
    logic [RW-1:0]  w_dist;
    assign w_dist = RW'(w_sroot[NSQ]);
    logic [DW+CW-1:0] r_as [3];
    logic [QDW-1:0]   r_den;
    logic [RW-1:0]    r_fall;
    logic [CW-1:0]    w_sabs;
    assign w_sabs = r_str[CW-1] ? CW'(-r_str) : r_str;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[SA+1] <= r_side[SA];
            for (int k = 0; k < 3; k++) r_as[k] <= r_abq[NSQ-1][k] * w_sabs;
            r_den  <= QDW'(r_rad) * QDW'(w_dist);
            r_fall <= r_rad - w_dist;
        end
    end

    logic [QNW:0] r_num [3];
    logic [QDW:0] r_den2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[SA+2] <= r_side[SA+1];
            for (int k = 0; k < 3; k++)
                r_num[k] <= ((QNW+1)'(r_as[k]) * (QNW+1)'(r_fall) << 1) +
                            (QNW+1)'(r_den);
            r_den2 <= {r_den, 1'b0};
        end
    end

    // divide chains, one per axis
    localparam int SD = SA + 2;
    logic [QDW+1:0] w_drem [3][NDV+1];
    logic [QNW:0]   w_dnum [3][NDV+1];
    logic [QDW:0]   r_dden [NDV];
    for (genvar a = 0; a < 3; a++) begin : g_ax
        assign w_drem[a][0] = '0;
        assign w_dnum[a][0] = r_num[a];
        for (genvar g = 0; g < NDV; g++) begin : g_dv
            vpi_div_stage u_dv (
                .i_clk(i_clk), .i_en(w_en),
                .i_den(g == 0 ? r_den2 : r_dden[g == 0 ? 0 : g-1]),
                .i_rem(w_drem[a][g]), .i_num(w_dnum[a][g]),
                .o_rem(w_drem[a][g+1]), .o_num(w_dnum[a][g+1])
            );
        end
    end
    for (genvar g = 0; g < NDV; g++) begin : g_dside
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[SD+1+g] <= r_side[SD+g];
                r_dden[g] <= (g == 0) ? r_den2 : r_dden[g == 0 ? 0 : g-1];
            end
        end
    end

    // final: add field, saturate, select held
    localparam int SF = SD + NDV;
    t_result r_res, w_res;
    logic signed [QNW+2:0] w_tot [3];
    logic signed [CW-1:0]  w_sat [3];
    logic w_clip;
    always_comb begin
        t_side s;
        s = r_side[SF];
        w_clip = 1'b0;
        w_tot[0] = (QNW+3)'(s.base_x);
        w_tot[1] = (QNW+3)'(s.base_y);
        w_tot[2] = (QNW+3)'(s.base_z);
        for (int k = 0; k < 3; k++) begin
            if (s.fld)
                w_tot[k] = s.neg[k] ? w_tot[k] - $signed({2'b0, w_dnum[k][NDV]})
                                    : w_tot[k] + $signed({2'b0, w_dnum[k][NDV]});
            if (w_tot[k] > (QNW+3)'((1 << (CW-1)) - 1)) begin
                w_sat[k] = {1'b0, {(CW-1){1'b1}}}; w_clip = 1'b1;
            end else if (w_tot[k] < -(QNW+3)'(1 << (CW-1))) begin
                w_sat[k] = {1'b1, {(CW-1){1'b0}}}; w_clip = 1'b1;
            end else begin
                w_sat[k] = w_tot[k][CW-1:0];
            end
        end
        if (s.item.hold) begin
            w_res.next_x = s.item.pos_x; w_res.next_y = s.item.pos_y;
            w_res.next_z = s.item.pos_z;
            w_res.prior_x = s.item.old_x; w_res.prior_y = s.item.old_y;
            w_res.prior_z = s.item.old_z;
            w_res.clipped = 1'b0;
        end else begin
            w_res.next_x = w_sat[0]; w_res.next_y = w_sat[1]; w_res.next_z = w_sat[2];
            w_res.prior_x = s.item.pos_x; w_res.prior_y = s.item.pos_y;
            w_res.prior_z = s.item.pos_z;
            w_res.clipped = w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_res <= w_res;
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata = {2'b0, r_res.prior_z, r_res.prior_y, r_res.prior_x,
                           r_res.next_z, r_res.next_y, r_res.next_x};
    assign m_axis_tuser = r_res.clipped;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
    a_hold_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[SF] && r_side[SF].item.hold |=> !m_axis_tuser)
        else $error("held item clipped");
endmodule

// File: test/verlet_particle_integrator_core_chk.sv
module verlet_particle_integrator_core_chk import vpi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [62:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);
    logic signed [20:0] acc_r [3];
    logic [16:0]        keep_r;
    logic [19:0]        rad_r;
    logic signed [20:0] str_r;
    logic [62:0]        ctr_r;

    t_result particle_q[$];

    // bitwise integer square root, floor
    function automatic longint floor_sqrt(longint n);
        longint r, b, m;
        r = 0;
        m = n;
        b = longint'(1) << 62;
        while (b > m) b = b >> 2;
        while (b != 0) begin
            if (m >= r + b) begin
                m = m - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_result advance_particle(logic [127:0] d, logic h);
        t_result res;
        longint p [3];
        longint o [3];
        longint a [3];
        longint dl [3];
        longint sq, root_d, den, fall, mag, q, kp, v, s, rad;
        bit near, clip;
        for (int i = 0; i < 3; i++) begin
            p[i] = $signed(d[21*i +: 21]);
            o[i] = $signed(d[63 + 21*i +: 21]);
            a[i] = acc_r[i];
        end
        res = '0;
        res.prior_x = h ? o[0] : p[0];
        res.prior_y = h ? o[1] : p[1];
        res.prior_z = h ? o[2] : p[2];
        if (h) begin
            res.next_x = p[0];
            res.next_y = p[1];
            res.next_z = p[2];
            return res;
        end
        rad = rad_r;
        if (rad != 0) begin
            near = 1;
            for (int i = 0; i < 3; i++) begin
                dl[i] = longint'($signed(ctr_r[21*i +: 21])) - p[i];
                if ((dl[i] < 0 ? -dl[i] : dl[i]) >= rad) near = 0;
            end
            if (near) begin
                sq = dl[0]*dl[0] + dl[1]*dl[1] + dl[2]*dl[2];
                if (sq != 0 && sq < rad * rad) begin
                    root_d = floor_sqrt(sq);
                    den = rad * root_d;
                    fall = rad - root_d;
                    for (int i = 0; i < 3; i++) begin
                        // magnitude fits 62 bits, so unsigned 64-bit math is exact
                        mag = (dl[i] < 0 ? -dl[i] : dl[i]) * (str_r < 0 ? -longint'(str_r)
                              : longint'(str_r)) * fall;
                        q = longint'((2 * longint'(unsigned'(mag)) + den) / (2 * den));
                        a[i] += ((dl[i] < 0) != (str_r < 0)) ? -q : q;
                    end
                end
            end
        end
        kp = keep_r > KEEP_ONE ? KEEP_ONE : keep_r;
        clip = 0;
        for (int i = 0; i < 3; i++) begin
            v = ((p[i] - o[i]) * kp + 32768) >>> 16;
            s = p[i] + v + a[i];
            if (s > 1048575) begin s = 1048575; clip = 1; end
            if (s < -1048576) begin s = -1048576; clip = 1; end
            case (i)
                0: res.next_x = s;
                1: res.next_y = s;
                default: res.next_z = s;
            endcase
        end
        res.clipped = clip;
        return res;
    endfunction

    assign o_pending = particle_q.size();

    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (!i_rst_n) begin
            acc_r  <= '{default: '0};
            keep_r <= KEEP_ONE;
            rad_r  <= '0;
            str_r  <= '0;
            ctr_r  <= '0;
            particle_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACC_X: acc_r[0] <= i_cfg_data[20:0];
                    REG_ACC_Y: acc_r[1] <= i_cfg_data[20:0];
                    REG_ACC_Z: acc_r[2] <= i_cfg_data[20:0];
                    REG_KEEP:  keep_r   <= i_cfg_data[16:0];
                    REG_RAD:   rad_r    <= i_cfg_data[19:0];
                    REG_STR:   str_r    <= i_cfg_data[20:0];
                    REG_CTR:   ctr_r    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                particle_q.insert(particle_q.size(),
                                  advance_particle(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                got = '0;
                got.next_x  = m_axis_tdata[20:0];
                got.next_y  = m_axis_tdata[41:21];
                got.next_z  = m_axis_tdata[62:42];
                got.prior_x = m_axis_tdata[83:63];
                got.prior_y = m_axis_tdata[104:84];
                got.prior_z = m_axis_tdata[125:105];
                got.clipped = m_axis_tuser;
                if (particle_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = particle_q.pop_front();
                    if (got.next_x !== exp_r.next_x || got.next_y !== exp_r.next_y ||
                        got.next_z !== exp_r.next_z || got.prior_x !== exp_r.prior_x ||
                        got.prior_y !== exp_r.prior_y || got.prior_z !== exp_r.prior_z ||
                        got.clipped !== exp_r.clipped) begin
                        $display("%0t: expected next %0d %0d %0d prior %0d %0d %0d clip %0b",
                                 $time, exp_r.next_x, exp_r.next_y, exp_r.next_z,
                                 exp_r.prior_x, exp_r.prior_y, exp_r.prior_z, exp_r.clipped);
                        $display("%0t: actual   next %0d %0d %0d prior %0d %0d %0d clip %0b",
                                 $time, got.next_x, got.next_y, got.next_z,
                                 got.prior_x, got.prior_y, got.prior_z, got.clipped);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: test/verlet_particle_integrator_core_tb.sv
module verlet_particle_integrator_core_tb import vpi_pkg::*;;
    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 0;
    logic [2:0]   i_cfg_idx = '0;
    logic [62:0]  i_cfg_data = '0;
    int           errors, pending;
    int           send_idle, recv_stall;
    logic         in_took = 0;

    always #5 i_clk = ~i_clk;

    verlet_particle_integrator_core u_top (.*);

    verlet_particle_integrator_core_chk u_chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    // input handshake as seen at the rising edge
    always @(posedge i_clk)
        in_took <= s_axis_tvalid && s_axis_tready;

    task automatic write_reg(logic [2:0] idx, logic [62:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic send_particle(logic signed [20:0] px, py, pz, ox, oy, oz, logic h);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {2'b0, oz, oy, ox, pz, py, px};
        s_axis_tuser  <= h;
        do @(negedge i_clk); while (!in_took);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic logic signed [20:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 21'sh0FFFFF : 21'sh100000;
            1: return $signed(21'($urandom_range(4095))) - 2048;
            default: return 21'($urandom);
        endcase
    endfunction

    task automatic random_particle(logic signed [20:0] cx, cy, cz, int spread);
        logic signed [20:0] px, py, pz;
        if (spread > 0 && $urandom_range(3) != 0) begin
            px = cx + $signed(21'($urandom_range(2*spread))) - spread;
            py = cy + $signed(21'($urandom_range(2*spread))) - spread;
            pz = cz + $signed(21'($urandom_range(2*spread))) - spread;
        end else begin
            px = rnd_coord(); py = rnd_coord(); pz = rnd_coord();
        end
        if ($urandom_range(1))
            send_particle(px, py, pz, px - $signed(21'($urandom_range(400))) + 200,
                          py - $signed(21'($urandom_range(400))) + 200,
                          pz - $signed(21'($urandom_range(400))) + 200,
                          $urandom_range(7) == 0);
        else
            send_particle(px, py, pz, rnd_coord(), rnd_coord(), rnd_coord(),
                          $urandom_range(7) == 0);
    endtask

    initial begin
        #20000000;
        $display("verlet_particle_integrator_core verification failed");
        $finish;
    end

    initial begin
        logic signed [20:0] cx, cy, cz;
        int rad;
        send_idle = 0;
        recv_stall = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // reset settings: extremes and a held particle
        send_particle(21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF,
                      21'sh100000, 21'sh100000, 21'sh100000, 0);
        send_particle(21'sh100000, 21'sh100000, 21'sh100000,
                      21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF, 0);
        send_particle(21'sh0FFFFF, 21'sh100000, 0, 21'sh100000, 21'sh0FFFFF, 0, 1);
        send_particle(5, -5, 0, 4, -4, 0, 0);
        send_particle(-1, 1, 3, 0, 0, 2, 0);
        drain_pipe();
        // field: center, at-center, just inside, at radius, keep above one
        write_reg(REG_RAD, 20'd1024);
        write_reg(REG_STR, 21'sh0FFFFF);
        write_reg(REG_CTR, {21'sd100, -21'sd100, 21'sd0});
        write_reg(REG_KEEP, 17'h1FFFF);
        write_reg(REG_ACC_X, 21'sh0FFFFF);
        write_reg(REG_ACC_Y, 21'sh100000);
        write_reg(REG_ACC_Z, 21'sd7);
        send_particle(0, -100, 100, 0, -100, 100, 0);
        send_particle(1, -100, 100, 0, -100, 100, 0);
        send_particle(1023, -100, 100, 1023, -100, 100, 0);
        send_particle(1024, -100, 100, 1024, -100, 100, 0);
        send_particle(-500, 400, 300, -510, 400, 300, 0);
        send_particle(-500, 400, 300, -510, 400, 300, 1);
        drain_pipe();
        write_reg(REG_STR, 21'sh100000);
        write_reg(REG_RAD, 20'hFFFFF);
        write_reg(REG_KEEP, 17'd0);
        write_reg(REG_CTR, {21'sh100000, 21'sh0FFFFF, 21'sh100000});
        send_particle(0, 0, 0, 0, 0, 0, 0);
        send_particle(-1000, 1000, -1000, 0, 0, 0, 0);
        send_particle(21'sh100000, 21'sh0FFFFF, 21'sh100000, 0, 0, 0, 0);
        drain_pipe();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 76; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 76; end
                default: begin send_idle = 25; recv_stall = 25; end
            endcase
            cx = rnd_coord(); cy = rnd_coord(); cz = rnd_coord();
            rad = (ph == 7) ? 20'hFFFFF : ((ph % 3 == 0) ? 0 : $urandom_range(5000, 1));
            write_reg(REG_ACC_X, $urandom_range(1) ? 21'($urandom) : 21'($urandom_range(64)));
            write_reg(REG_ACC_Y, 21'($urandom));
            write_reg(REG_ACC_Z, -21'sd10);
            write_reg(REG_KEEP, (ph == 4) ? 17'd0 : 17'($urandom_range(65536, 60000)));
            write_reg(REG_RAD, rad);
            write_reg(REG_STR, 21'($urandom));
            write_reg(REG_CTR, {cz, cy, cx});
            for (int n = 0; n < 250; n++)
                random_particle(cx, cy, cz, rad > 0 ? rad : 0);
            drain_pipe();
        end
        if (errors == 0 && pending == 0) begin
            $display("verlet_particle_integrator_core verification clean");
        end else begin
            $display("verlet_particle_integrator_core verification failed");
        end
        $finish;
    end
endmodule
